>>> hdl/cramer_3x3_linear_solver_macros.svh
// Assertion macros used by the solver top level.
`ifndef CRAMER_3X3_LINEAR_SOLVER_MACROS_SVH
`define CRAMER_3X3_LINEAR_SOLVER_MACROS_SVH

// Same-cycle implication, sampled on i_clk, off during reset.
`define CR3_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("cr3 same-cycle check failed");

// Next-cycle implication, sampled on i_clk, off during reset.
`define CR3_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("cr3 next-cycle check failed");

`endif

>>> hdl/cr3_pkg.sv
// Package: request and result types and sizing constants of the 3x3 solver.
`timescale 1ns / 1ps
package cr3_pkg;

    localparam int COEF_WIDTH_DEF  = 16;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int QUEUE_DEPTH     = 4;
    localparam int SOL_WIDTH       = 64;

    localparam logic [SOL_WIDTH-1:0] SOL_POS_MAX = {1'b0, {(SOL_WIDTH-1){1'b1}}};
    localparam logic [SOL_WIDTH-1:0] SOL_NEG_MAX = {1'b1, {(SOL_WIDTH-1){1'b0}}};

    typedef struct packed {
        logic signed [15:0] a_row1;
        logic signed [15:0] a_row2;
        logic signed [15:0] a_row3;
        logic signed [15:0] b_row1;
        logic signed [15:0] b_row2;
        logic signed [15:0] b_row3;
        logic signed [15:0] c_row1;
        logic signed [15:0] c_row2;
        logic signed [15:0] c_row3;
        logic signed [15:0] rhs_row1;
        logic signed [15:0] rhs_row2;
        logic signed [15:0] rhs_row3;
    } t_req;

    typedef struct packed {
        logic signed [SOL_WIDTH-1:0] sol_x;
        logic signed [SOL_WIDTH-1:0] sol_y;
        logic signed [SOL_WIDTH-1:0] sol_z;
        logic                        singular;
        logic                        overflowed;
    } t_rsp;

endpackage

>>> hdl/cr3_req_if.sv
// Interfaces: request channel and result channel of the solver.
`timescale 1ns / 1ps
interface cr3_req_if;
    import cr3_pkg::*;
    logic valid;
    logic ready;
    t_req payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface cr3_rsp_if;
    import cr3_pkg::*;
    logic valid;
    logic ready;
    t_rsp payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

>>> hdl/cramer_3x3_linear_solver.sv
// Top level: 3x3 linear system solver by Cramer's rule, Q-format results.
//
//  channel  | dir | handshake         | payload
//  ---------+-----+-------------------+--------------------------------------
//  i_req    | in  | valid/ready       | nine coefficients, three known terms
//  o_rsp    | out | valid/ready       | sol_x/y/z, singular, overflowed
//
// One request per cycle sustained while the receiver holds o_rsp ready.
// A result passes in order through the remaining front stages, the queue,
// the divider entry stage, one divider stage per quotient bit (the
// one-bit-per-stage divider pipeline) and the result register.
// A four-entry queue sits between the determinant stages and the dividers,
// so the front keeps accepting while the back is stalled until the queue fills.
// Reset is synchronous, active low, and clears only valid bits, queue
// pointers and the fill count; no clearing pass is needed.
`timescale 1ns / 1ps
`include "cramer_3x3_linear_solver_macros.svh"
module cramer_3x3_linear_solver #(
    parameter int COEF_WIDTH = cr3_pkg::COEF_WIDTH_DEF,
    parameter int FRAC_BITS  = cr3_pkg::FRAC_BITS_DEF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    cr3_req_if.sink   i_req,
    cr3_rsp_if.source o_rsp
);
    import cr3_pkg::*;

    localparam int MAG_W = 3 * COEF_WIDTH;
    localparam int JOB_W = 4 * MAG_W + 4;

    logic             s_f_valid, s_f_ready;
    logic [JOB_W-1:0] s_f_job;
    logic             s_q_valid, s_q_ready;
    logic [JOB_W-1:0] s_q_job;

    cr3_front #(.CW(COEF_WIDTH), .MAG_W(MAG_W)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_req.valid),
        .o_ready (i_req.ready),
        .i_req   (i_req.payload),
        .o_valid (s_f_valid),
        .i_ready (s_f_ready),
        .o_job   (s_f_job)
    );

    cr3_fifo #(.WIDTH(JOB_W), .DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_f_valid),
        .o_ready (s_f_ready),
        .i_data  (s_f_job),
        .o_valid (s_q_valid),
        .i_ready (s_q_ready),
        .o_data  (s_q_job)
    );

    cr3_back #(.MAG_W(MAG_W), .FRAC(FRAC_BITS)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_q_valid),
        .o_ready (s_q_ready),
        .i_job   (s_q_job),
        .o_valid (o_rsp.valid),
        .i_ready (o_rsp.ready),
        .o_rsp   (o_rsp.payload)
    );

    // a singular system gives all-zero solutions and no overflow
    `CR3_ASSERT_SAME(a_sing_zero, o_rsp.valid && o_rsp.payload.singular, (o_rsp.payload.sol_x == '0) && (o_rsp.payload.sol_y == '0) && (o_rsp.payload.sol_z == '0) && !o_rsp.payload.overflowed)
    // overflow only on a solution pinned to a rail
    `CR3_ASSERT_SAME(a_ovf_rail, o_rsp.valid && o_rsp.payload.overflowed, (o_rsp.payload.sol_x == SOL_POS_MAX) || (o_rsp.payload.sol_x == SOL_NEG_MAX) || (o_rsp.payload.sol_y == SOL_POS_MAX) || (o_rsp.payload.sol_y == SOL_NEG_MAX) || (o_rsp.payload.sol_z == SOL_POS_MAX) || (o_rsp.payload.sol_z == SOL_NEG_MAX))
    // a full queue with a stalled back end holds the front end
    `CR3_ASSERT_NEXT(a_q_hold, s_f_valid && !s_f_ready && !s_q_ready, s_f_valid)
endmodule

>>> hdl/cr3_fifo.sv
// Short register queue between the determinant front end and the divider.
`timescale 1ns / 1ps
module cr3_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [WIDTH-1:0] o_data
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             s_push, s_pop;

    assign o_ready = (r_cnt != CNT_W'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];
    assign s_push  = i_valid && o_ready;
    assign s_pop   = o_valid && i_ready;

    // storage
    always_ff @(posedge i_clk) begin
        if (s_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (s_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (s_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (s_push && !s_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (s_pop && !s_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end
endmodule

>>> hdl/cr3_front.sv
// Front end: forms D, Dx, Dy, Dz in four stages and classifies the system.
`timescale 1ns / 1ps
module cr3_front #(
    parameter int CW    = 16,
    parameter int MAG_W = 48
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  cr3_pkg::t_req     i_req,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [4*MAG_W+3:0] o_job
);
    import cr3_pkg::*;

    localparam int P2  = 2 * CW;
    localparam int M_W = 2 * CW + 1;
    localparam int T_W = 3 * CW + 1;
    localparam int S_W = 3 * CW + 3;

    logic en;
    logic r_v1, r_v2, r_v3, r_v4;

    logic signed [CW-1:0] s_a [3];
    logic signed [CW-1:0] s_b [3];
    logic signed [CW-1:0] s_c [3];
    logic signed [CW-1:0] s_t [3];

    logic signed [P2-1:0]  r_pm [6];
    logic signed [P2-1:0]  r_pn [6];
    logic signed [P2-1:0]  r_pp [6];
    logic signed [CW-1:0]  r_a1 [3];
    logic signed [CW-1:0]  r_t1 [3];
    logic signed [M_W-1:0] r_m [3];
    logic signed [M_W-1:0] r_n [3];
    logic signed [M_W-1:0] r_p [3];
    logic signed [CW-1:0]  r_a2 [3];
    logic signed [CW-1:0]  r_t2 [3];
    logic signed [T_W-1:0] r_dd [3];
    logic signed [T_W-1:0] r_dx [3];
    logic signed [T_W-1:0] r_dy [3];
    logic signed [T_W-1:0] r_dz [3];

    logic signed [S_W-1:0] s_d, s_x, s_y, s_z;
    logic [S_W-1:0]        s_ad, s_ax, s_ay, s_az;
    logic [4*MAG_W+3:0]    r_job;

    assign en      = !r_v4 || i_ready;
    assign o_ready = en;
    assign o_valid = r_v4;
    assign o_job   = r_job;

    // low CW bits of each field
    assign s_a[0] = i_req.a_row1[CW-1:0];
    assign s_a[1] = i_req.a_row2[CW-1:0];
    assign s_a[2] = i_req.a_row3[CW-1:0];
    assign s_b[0] = i_req.b_row1[CW-1:0];
    assign s_b[1] = i_req.b_row2[CW-1:0];
    assign s_b[2] = i_req.b_row3[CW-1:0];
    assign s_c[0] = i_req.c_row1[CW-1:0];
    assign s_c[1] = i_req.c_row2[CW-1:0];
    assign s_c[2] = i_req.c_row3[CW-1:0];
    assign s_t[0] = i_req.rhs_row1[CW-1:0];
    assign s_t[1] = i_req.rhs_row2[CW-1:0];
    assign s_t[2] = i_req.rhs_row3[CW-1:0];

    // stage 1: pair products for the 2x2 minors
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pm[0] <= s_b[1] * s_c[2];  r_pm[1] <= s_b[2] * s_c[1];
            r_pm[2] <= s_b[0] * s_c[2];  r_pm[3] <= s_b[2] * s_c[0];
            r_pm[4] <= s_b[0] * s_c[1];  r_pm[5] <= s_b[1] * s_c[0];
            r_pn[0] <= s_a[1] * s_c[2];  r_pn[1] <= s_a[2] * s_c[1];
            r_pn[2] <= s_a[0] * s_c[2];  r_pn[3] <= s_a[2] * s_c[0];
            r_pn[4] <= s_a[0] * s_c[1];  r_pn[5] <= s_a[1] * s_c[0];
            r_pp[0] <= s_a[1] * s_b[2];  r_pp[1] <= s_a[2] * s_b[1];
            r_pp[2] <= s_a[0] * s_b[2];  r_pp[3] <= s_a[2] * s_b[0];
            r_pp[4] <= s_a[0] * s_b[1];  r_pp[5] <= s_a[1] * s_b[0];
            r_a1    <= s_a;
            r_t1    <= s_t;
        end
    end

    // stage 2: minors of (b,c), (a,c), (a,b)
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                r_m[k] <= M_W'(r_pm[2*k]) - M_W'(r_pm[2*k+1]);
                r_n[k] <= M_W'(r_pn[2*k]) - M_W'(r_pn[2*k+1]);
                r_p[k] <= M_W'(r_pp[2*k]) - M_W'(r_pp[2*k+1]);
            end
            r_a2 <= r_a1;
            r_t2 <= r_t1;
        end
    end

    // stage 3: cofactor products
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                r_dd[k] <= r_a2[k] * r_m[k];
                r_dx[k] <= r_t2[k] * r_m[k];
                r_dy[k] <= r_t2[k] * r_n[k];
                r_dz[k] <= r_t2[k] * r_p[k];
            end
        end
    end

    // stage 4: determinants, magnitudes and signs
    always_comb begin
        s_d  = S_W'(r_dd[0]) - S_W'(r_dd[1]) + S_W'(r_dd[2]);
        s_x  = S_W'(r_dx[0]) - S_W'(r_dx[1]) + S_W'(r_dx[2]);
        s_y  = S_W'(r_dy[1]) - S_W'(r_dy[0]) - S_W'(r_dy[2]);
        s_z  = S_W'(r_dz[0]) - S_W'(r_dz[1]) + S_W'(r_dz[2]);
        s_ad = s_d[S_W-1] ? -s_d : s_d;
        s_ax = s_x[S_W-1] ? -s_x : s_x;
        s_ay = s_y[S_W-1] ? -s_y : s_y;
        s_az = s_z[S_W-1] ? -s_z : s_z;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_job <= {(s_d == '0),
                      s_x[S_W-1] ^ s_d[S_W-1],
                      s_y[S_W-1] ^ s_d[S_W-1],
                      s_z[S_W-1] ^ s_d[S_W-1],
                      s_ad[MAG_W-1:0], s_ax[MAG_W-1:0],
                      s_ay[MAG_W-1:0], s_az[MAG_W-1:0]};
        end
    end

    // stage valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end
endmodule

>>> hdl/cr3_back.sv
// Back end: three pipelined restoring dividers, saturation and result register.
`timescale 1ns / 1ps
module cr3_back #(
    parameter int MAG_W = 48,
    parameter int FRAC  = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [4*MAG_W+3:0] i_job,
    output logic               o_valid,
    input  logic               i_ready,
    output cr3_pkg::t_rsp      o_rsp
);
    import cr3_pkg::*;

    localparam int NUM_W = MAG_W + FRAC;

    logic en, s_load;
    logic r_ov;
    t_rsp r_rsp;

    logic             r_v    [0:NUM_W];
    logic             r_sing [0:NUM_W];
    logic [2:0]       r_neg  [0:NUM_W];
    logic [MAG_W-1:0] r_d    [0:NUM_W];
    logic [MAG_W-1:0] r_rem  [0:NUM_W][0:2];
    logic [NUM_W-1:0] r_quo  [0:NUM_W][0:2];

    logic [MAG_W-1:0]     s_mag [0:2];
    logic [SOL_WIDTH-1:0] s_q   [0:2];
    logic [SOL_WIDTH-1:0] s_sol [0:2];
    logic [2:0]           s_sat;

    assign en      = !r_ov || i_ready;
    assign o_ready = en;
    assign s_load  = en && i_valid;
    assign o_valid = r_ov;
    assign o_rsp   = r_rsp;

    assign s_mag[0] = i_job[3*MAG_W-1:2*MAG_W];
    assign s_mag[1] = i_job[2*MAG_W-1:MAG_W];
    assign s_mag[2] = i_job[MAG_W-1:0];

    // entry stage: scaled numerators, empty remainders
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sing[0] <= i_job[4*MAG_W+3];
            r_neg[0]  <= i_job[4*MAG_W+2:4*MAG_W];
            r_d[0]    <= i_job[4*MAG_W-1:3*MAG_W];
            for (int l = 0; l < 3; l++) begin
                r_rem[0][l] <= '0;
                r_quo[0][l] <= NUM_W'(s_mag[l]) << FRAC;
            end
        end
    end

    // one quotient bit per stage, per lane
    for (genvar k = 0; k < NUM_W; k++) begin : g_stage
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_sing[k+1] <= r_sing[k];
                r_neg[k+1]  <= r_neg[k];
                r_d[k+1]    <= r_d[k];
            end
        end
        for (genvar l = 0; l < 3; l++) begin : g_lane
            logic [MAG_W:0] s_ext, s_trial;
            logic           s_bit;
            always_comb begin
                s_ext   = {r_rem[k][l], r_quo[k][l][NUM_W-1]};
                s_trial = s_ext - {1'b0, r_d[k]};
                s_bit   = !s_trial[MAG_W];
            end
            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_rem[k+1][l] <= s_bit ? s_trial[MAG_W-1:0] : s_ext[MAG_W-1:0];
                    r_quo[k+1][l] <= {r_quo[k][l][NUM_W-2:0], s_bit};
                end
            end
        end
    end

    // sign and saturation; sign bits are packed x, y, z from the top down
    always_comb begin
        for (int l = 0; l < 3; l++) begin
            s_q[l] = SOL_WIDTH'(r_quo[NUM_W][l]);
            if (r_neg[NUM_W][2-l]) begin
                s_sat[l] = (s_q[l] > SOL_NEG_MAX);
                s_sol[l] = s_sat[l] ? SOL_NEG_MAX : -s_q[l];
            end else begin
                s_sat[l] = (s_q[l] > SOL_POS_MAX);
                s_sol[l] = s_sat[l] ? SOL_POS_MAX : s_q[l];
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (en) begin
            if (r_sing[NUM_W]) begin
                r_rsp.sol_x      <= '0;
                r_rsp.sol_y      <= '0;
                r_rsp.sol_z      <= '0;
                r_rsp.overflowed <= 1'b0;
            end else begin
                r_rsp.sol_x      <= s_sol[0];
                r_rsp.sol_y      <= s_sol[1];
                r_rsp.sol_z      <= s_sol[2];
                r_rsp.overflowed <= |s_sat;
            end
            r_rsp.singular <= r_sing[NUM_W];
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= NUM_W; k++) begin
                r_v[k] <= 1'b0;
            end
            r_ov <= 1'b0;
        end else if (en) begin
            r_v[0] <= s_load;
            for (int k = 0; k < NUM_W; k++) begin
                r_v[k+1] <= r_v[k];
            end
            r_ov <= r_v[NUM_W];
        end
    end
endmodule

>>> bench/cramer_3x3_linear_solver_tb.sv
// Testbench for the 3x3 Cramer solver: directed and random systems, scoreboard check.
`timescale 1ns / 1ps
module cramer_3x3_linear_solver_tb;
    import cr3_pkg::*;

    localparam int LATENCY   = 4 + 1 + (3 * COEF_WIDTH_DEF + FRAC_BITS_DEF) + 1;
    localparam int WDOG_MAX  = 20000;
    localparam int N_RANDOM  = 1630;

    typedef enum int {IDLE_NONE, IDLE_SRC, IDLE_SNK, IDLE_BOTH} t_idle;

    logic i_clk;
    logic i_rst_n;

    cr3_req_if req_ch ();
    cr3_rsp_if rsp_ch ();

    cramer_3x3_linear_solver i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_ch.sink),
        .o_rsp  (rsp_ch.source)
    );

    t_req  pending_systems[$];
    t_rsp  expected_solutions[$];
    t_idle idle_mode;
    int    mismatch_count;
    int    wdog_cycles;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Signed fixed-point quotient, truncated toward zero, saturated to 64 bits
    function automatic logic [SOL_WIDTH-1:0] fixed_quotient(
        input logic signed [63:0] num, input logic signed [63:0] den, inout bit sat);
        logic [127:0] n_mag;
        logic [127:0] d_mag;
        logic [127:0] q;
        bit           neg;
        n_mag = (num < 0) ? 128'(-num) : 128'(num);
        d_mag = (den < 0) ? 128'(-den) : 128'(den);
        q     = (n_mag << FRAC_BITS_DEF) / d_mag;
        neg   = (num < 0) != (den < 0);
        if (neg) begin
            if (q > 128'(SOL_NEG_MAX)) begin
                sat = 1'b1;
                return SOL_NEG_MAX;
            end
            return -q[63:0];
        end
        if (q > 128'(SOL_POS_MAX)) begin
            sat = 1'b1;
            return SOL_POS_MAX;
        end
        return q[63:0];
    endfunction

    // Determinant of columns p, q, r
    function automatic logic signed [63:0] det_cols(
        input logic signed [63:0] p1, p2, p3, q1, q2, q3, r1, r2, r3);
        return p1 * q2 * r3 + q1 * r2 * p3 + r1 * p2 * q3
             - r1 * q2 * p3 - q1 * p2 * r3 - p1 * r2 * q3;
    endfunction

    function automatic t_rsp solve_system(input t_req s);
        logic signed [63:0] a1, a2, a3, b1, b2, b3, c1, c2, c3, t1, t2, t3;
        logic signed [63:0] d, dx, dy, dz;
        t_rsp r;
        bit   sat;
        a1 = s.a_row1; a2 = s.a_row2; a3 = s.a_row3;
        b1 = s.b_row1; b2 = s.b_row2; b3 = s.b_row3;
        c1 = s.c_row1; c2 = s.c_row2; c3 = s.c_row3;
        t1 = s.rhs_row1; t2 = s.rhs_row2; t3 = s.rhs_row3;
        d  = det_cols(a1, a2, a3, b1, b2, b3, c1, c2, c3);
        dx = det_cols(t1, t2, t3, b1, b2, b3, c1, c2, c3);
        dy = det_cols(a1, a2, a3, t1, t2, t3, c1, c2, c3);
        dz = det_cols(a1, a2, a3, b1, b2, b3, t1, t2, t3);
        r   = '0;
        sat = 1'b0;
        if (d == 0) begin
            r.singular = 1'b1;
            return r;
        end
        r.sol_x      = fixed_quotient(dx, d, sat);
        r.sol_y      = fixed_quotient(dy, d, sat);
        r.sol_z      = fixed_quotient(dz, d, sat);
        r.overflowed = sat;
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        mismatch_count++;
    endtask

    function automatic logic [15:0] pick_coef();
        case ($urandom_range(0, 9))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'($urandom_range(0, 4)) - 16'd2;
            3, 4:    return 16'($urandom_range(0, 20)) - 16'd10;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic t_req random_system();
        t_req s;
        logic [15:0] f[12];
        foreach (f[k]) f[k] = pick_coef();
        s = {f[0], f[1], f[2], f[3], f[4], f[5], f[6], f[7], f[8], f[9], f[10], f[11]};
        case ($urandom_range(0, 9))
            0: begin
                // two equal rows: singular
                s.a_row2 = s.a_row1; s.b_row2 = s.b_row1; s.c_row2 = s.c_row1;
            end
            1: begin
                // 2x2 embedded system
                s.a_row3 = '0; s.b_row3 = '0; s.c_row1 = '0; s.c_row2 = '0;
                s.c_row3 = 16'sd1; s.rhs_row3 = '0;
            end
            default: ;
        endcase
        return s;
    endfunction

    function automatic t_req make_system(input logic [15:0] a1, a2, a3, b1, b2, b3,
                                         c1, c2, c3, t1, t2, t3);
        return {a1, a2, a3, b1, b2, b3, c1, c2, c3, t1, t2, t3};
    endfunction

    // Driver: presents the head of the queue, random source idling
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_ch.valid   <= 1'b0;
            req_ch.payload <= '0;
        end else if (!req_ch.valid || req_ch.ready) begin
            t_req nxt;
            bit   gap;
            if (req_ch.valid) begin
                expected_solutions.push_back(solve_system(req_ch.payload));
                void'(pending_systems.pop_front());
            end
            gap = (idle_mode == IDLE_SRC && $urandom_range(0, 99) < 67)
               || (idle_mode == IDLE_BOTH && $urandom_range(0, 99) < 24);
            if (pending_systems.size() != 0 && !gap) begin
                nxt = pending_systems[0];
                req_ch.valid   <= 1'b1;
                req_ch.payload <= nxt;
            end else begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    // Monitor: result check and receiver stalls
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
            wdog_cycles  <= 0;
        end else begin
            t_rsp got;
            t_rsp want;
            if (rsp_ch.valid && rsp_ch.ready) begin
                got = rsp_ch.payload;
                if (expected_solutions.size() == 0) begin
                    report_mismatch("result with nothing expected");
                end else begin
                    want = expected_solutions.pop_front();
                    if (got.sol_x !== want.sol_x)
                        report_mismatch($sformatf("sol_x %h exp %h", got.sol_x, want.sol_x));
                    if (got.sol_y !== want.sol_y)
                        report_mismatch($sformatf("sol_y %h exp %h", got.sol_y, want.sol_y));
                    if (got.sol_z !== want.sol_z)
                        report_mismatch($sformatf("sol_z %h exp %h", got.sol_z, want.sol_z));
                    if (got.singular !== want.singular)
                        report_mismatch($sformatf("singular %b exp %b", got.singular,
                                                  want.singular));
                    if (got.overflowed !== want.overflowed)
                        report_mismatch($sformatf("overflowed %b exp %b", got.overflowed,
                                                  want.overflowed));
                end
            end
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                wdog_cycles <= 0;
            else
                wdog_cycles <= wdog_cycles + 1;
            case (idle_mode)
                IDLE_SNK:  rsp_ch.ready <= ($urandom_range(0, 99) >= 67);
                IDLE_BOTH: rsp_ch.ready <= ($urandom_range(0, 99) >= 24);
                default:   rsp_ch.ready <= 1'b1;
            endcase
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        if (wdog_cycles >= WDOG_MAX) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Stimulus and end of run
    initial begin
        t_req s;
        mismatch_count = 0;
        idle_mode      = IDLE_NONE;
        i_rst_n        = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // identity, singular zero, extremes, 2x2, overflow, negative results
        pending_systems.push_back(make_system(1, 0, 0, 0, 1, 0, 0, 0, 1, 5, -7, 3));
        pending_systems.push_back(make_system(0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 2, 3));
        pending_systems.push_back(make_system(16'h8000, 0, 0, 0, 16'h8000, 0, 0, 0,
                                              16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF));
        pending_systems.push_back(make_system(1, 0, 0, 0, 1, 0, 0, 0, 1,
                                              16'h8000, 16'h7FFF, 16'h8000));
        pending_systems.push_back(make_system(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                                              16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
                                              16'h7FFF, 1, 1, 1));
        pending_systems.push_back(make_system(2, 1, 0, 3, -4, 0, 0, 0, 1, 7, -2, 0));
        pending_systems.push_back(make_system(3, 1, 0, 1, 3, 0, 0, 0, 1, 1, 0, 0));
        pending_systems.push_back(make_system(16'h8000, 16'h7FFF, 1, 16'h7FFF, 16'h8000,
                                              -1, 16'h8000, 1, 16'h7FFF, 16'hFFFF,
                                              16'h8000, 16'h7FFF));
        pending_systems.push_back(make_system(1, 1, 0, 1, 0, 1, 0, 1, 1,
                                              16'h7FFF, 16'h8000, 16'h7FFF));
        pending_systems.push_back(make_system(-1, 0, 0, 0, -1, 0, 0, 0, -1,
                                              16'h8000, 16'h8000, 16'h8000));
        pending_systems.push_back(make_system(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA,
                                              16'h5555, 16'hAAAA, 16'h1234, 16'hFEDC,
                                              16'h0F0F, 16'hF0F0, 16'h00FF, 16'hFF00));
        pending_systems.push_back(make_system(2, 4, 6, 1, 2, 3, 5, 1, 7, 3, 3, 3));

        for (int ph = 0; ph < 4; ph++) begin
            idle_mode = t_idle'(ph);
            for (int k = 0; k < N_RANDOM / 4; k++) begin
                s = random_system();
                pending_systems.push_back(s);
            end
            wait (pending_systems.size() == 0 && expected_solutions.size() == 0);
            @(posedge i_clk);
        end
        idle_mode = IDLE_NONE;
        repeat (LATENCY + 20) @(posedge i_clk);
        if (mismatch_count == 0 && expected_solutions.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

>>> cramer_3x3_linear_solver.f
+incdir+hdl
hdl/cr3_pkg.sv
hdl/cr3_req_if.sv
hdl/cr3_fifo.sv
hdl/cr3_front.sv
hdl/cr3_back.sv
hdl/cramer_3x3_linear_solver.sv
bench/cramer_3x3_linear_solver_tb.sv
